>>> sv/doi_pkg.sv
// package for the differential odometry integrator
// holds payload and control types, fixed-point constants and the arctangent table
// no dependencies
`default_nettype none

package doi_pkg;

  localparam int ENC_W         = 32;
  localparam int POS_W         = 48;
  localparam int HEAD_W        = 16;
  localparam int QUAD_W        = 2;

  localparam int CORDIC_STEPS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int WORK_FRAC     = 29;
  localparam int ATAN_LEN      = 24;
  localparam int ATAN_W        = 30;
  localparam int ROT_STEPS     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int ITER_W        = $clog2(ATAN_LEN);
  localparam logic [ITER_W-1:0] ROT_LAST = ITER_W'(ROT_STEPS - 1);
  localparam int ROUND_SHIFT   = WORK_FRAC - FRACTION_BITS;

  localparam int DELTA_W       = ENC_W + 1;
  localparam int SUM_W         = ENC_W + 2;
  localparam int GAIN_W        = 29;
  localparam int PROD_W        = SUM_W + GAIN_W;
  localparam int WORK_W        = 64;
  localparam int ANG_W         = 34;
  localparam logic signed [GAIN_W-1:0] GAIN_Q28 = 29'sd163008219;
  localparam logic signed [WORK_W-1:0] ROUND_ADD = 64'sd1 <<< (ROUND_SHIFT - 1);

  // gyro to binary angle: floor((32 g + 22 + 45 * 2^31) / 45)
  localparam int DVD_W         = 40;
  localparam int DIV_DIGIT_W   = 8;
  localparam int DIV_CYCLES    = DVD_W / DIV_DIGIT_W;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);
  localparam int GYRO_SHIFT    = 5;
  localparam logic [6:0] GYRO_DIVISOR = 7'd45;
  localparam int REM_W         = 6;
  localparam logic [DVD_W-1:0] GYRO_OFFSET = 40'd22 + 40'd45 * 40'd2147483648;

  typedef struct packed {
    logic signed [ENC_W-1:0] right_position;
    logic signed [ENC_W-1:0] left_position;
    logic signed [ENC_W-1:0] gyro_rotation;
  } doi_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HEAD_W-1:0]       heading;
  } doi_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FOLD,
    ST_ROT,
    ST_ACC
  } doi_state_e;

  typedef struct packed {
    logic              cap;
    logic              prep;
    logic              div_step;
    logic              sum;
    logic              mul;
    logic              fold;
    logic              rot;
    logic              acc;
    logic [ITER_W-1:0] iter;
  } doi_cmd_t;

  function automatic logic [ATAN_W-1:0] doi_atan(input logic [ITER_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/doi_ctrl.sv
// controller state machine for the odometry integrator
// sequences capture, gyro division, cordic rotation and accumulation; uses doi_pkg
`default_nettype none

module doi_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            out_stall_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output doi_pkg::doi_cmd_t    cmd_o
);
  import doi_pkg::*;

  doi_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ITER_W-1:0]    iter_q, iter_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == DIV_LAST) state_d = ST_FOLD;
      ST_FOLD: state_d = ST_ROT;
      ST_ROT:  if (iter_q == ROT_LAST) state_d = ST_ACC;
      ST_ACC:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.iter  = iter_q;
    in_stall_o  = 1'b1;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.cap  = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.sum      = (cnt_q == DIV_CNT_W'(0));
        cmd_o.mul      = (cnt_q == DIV_CNT_W'(1));
        cnt_d          = cnt_q + DIV_CNT_W'(1);
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        iter_d     = '0;
      end
      ST_ROT: begin
        cmd_o.rot = 1'b1;
        iter_d    = iter_q + ITER_W'(1);
      end
      ST_ACC: begin
        if (out_free) begin
          cmd_o.acc   = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> sv/doi_datapath.sv
// datapath for the odometry integrator: deltas, gyro divider, gain multiply,
// iterative cordic rotator, wrapping accumulators and output register; uses doi_pkg
`default_nettype none

module doi_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire doi_pkg::doi_cmd_t    cmd_i,
  input  wire doi_pkg::doi_in_t     in_data_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [doi_pkg::QUAD_W-1:0] cfg_wdata_i,
  output doi_pkg::doi_out_t         out_data_o
);
  import doi_pkg::*;

  doi_in_t                    in_q;
  doi_out_t                   out_q;
  logic [QUAD_W-1:0]          quad_q;
  logic signed [ENC_W-1:0]    last_right_q, last_left_q;
  logic signed [POS_W-1:0]    acc_x_q, acc_y_q;
  logic signed [DELTA_W-1:0]  dr_q, dl_q;
  logic signed [SUM_W-1:0]    s_q;
  logic [DVD_W-1:0]           dvd_q;
  logic [REM_W-1:0]           rem_q;
  logic [HEAD_W-1:0]          quot_q;
  logic [HEAD_W-1:0]          head_q;
  logic signed [WORK_W-1:0]   x_q, y_q;
  logic signed [ANG_W-1:0]    z_q;

  logic signed [PROD_W-1:0]   prod;
  logic [HEAD_W-1:0]          head_d, ang;
  logic                       fold;
  logic [6:0]                 rem;
  logic [DIV_DIGIT_W-1:0]     qdig;
  logic signed [WORK_W-1:0]   xs, ys, x_n, y_n, xr, yr;
  logic signed [ANG_W-1:0]    at, z_n;
  logic signed [POS_W-1:0]    acc_x_n, acc_y_n;

  assign prod = PROD_W'(s_q) * PROD_W'(GAIN_Q28);

  // eight restoring steps on the narrow remainder
  always_comb begin
    rem  = {1'b0, rem_q};
    qdig = '0;
    for (int k = 0; k < DIV_DIGIT_W; k++) begin
      rem = {rem[REM_W-1:0], dvd_q[DVD_W-1-k]};
      if (rem >= GYRO_DIVISOR) begin
        rem               = rem - GYRO_DIVISOR;
        qdig[DIV_DIGIT_W-1-k] = 1'b1;
      end
    end
  end

  assign head_d = {quad_q, {(HEAD_W-QUAD_W){1'b0}}} - quot_q;
  assign fold   = head_d[HEAD_W-1] ^ head_d[HEAD_W-2];
  assign ang    = {head_d[HEAD_W-1] ^ fold, head_d[HEAD_W-2:0]};

  always_comb begin
    xs = x_q >>> cmd_i.iter;
    ys = y_q >>> cmd_i.iter;
    at = ANG_W'(doi_atan(cmd_i.iter));
    if (!z_q[ANG_W-1]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
  end

  assign xr      = (x_q + ROUND_ADD) >>> ROUND_SHIFT;
  assign yr      = (y_q + ROUND_ADD) >>> ROUND_SHIFT;
  assign acc_x_n = acc_x_q + xr[POS_W-1:0];
  assign acc_y_n = acc_y_q + yr[POS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q       <= '0;
      last_right_q <= '0;
      last_left_q  <= '0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
    end else begin
      if (cfg_we_i) quad_q <= cfg_wdata_i;
      if (cmd_i.prep) begin
        last_right_q <= in_q.right_position;
        last_left_q  <= in_q.left_position;
      end
      if (cmd_i.acc) begin
        acc_x_q <= acc_x_n;
        acc_y_q <= acc_y_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) in_q <= in_data_i;
    if (cmd_i.prep) begin
      dr_q   <= DELTA_W'(in_q.right_position) - DELTA_W'(last_right_q);
      dl_q   <= DELTA_W'(in_q.left_position) - DELTA_W'(last_left_q);
      dvd_q  <= (DVD_W'(in_q.gyro_rotation) <<< GYRO_SHIFT) + GYRO_OFFSET;
      rem_q  <= '0;
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q  <= dvd_q << DIV_DIGIT_W;
      rem_q  <= rem[REM_W-1:0];
      quot_q <= {quot_q[HEAD_W-DIV_DIGIT_W-1:0], qdig};
    end
    if (cmd_i.sum) s_q <= SUM_W'(dr_q) + SUM_W'(dl_q);
    if (cmd_i.mul) x_q <= WORK_W'(prod);
    if (cmd_i.fold) begin
      head_q <= head_d;
      x_q    <= fold ? -x_q : x_q;
      y_q    <= '0;
      z_q    <= {{(ANG_W-HEAD_W-16){ang[HEAD_W-1]}}, ang, 16'b0};
    end
    if (cmd_i.rot) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
    if (cmd_i.acc) begin
      out_q.pos_x   <= acc_x_n;
      out_q.pos_y   <= acc_y_n;
      out_q.heading <= head_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> sv/differential_odometry_integrator.sv
// top level of the differential drive odometry integrator
// a request is taken only in idle; its result becomes valid once these steps are through
// (prep, gyro divider at 8 quotient bits each step, fold, 16 cordic steps, accumulate once the output is free)
// a new request waits until the last one is done, as the single shared cordic stage and divider serve one at a time
// reset (async, active low) clears encoder history, accumulators and the quadrant register
`default_nettype none

module differential_odometry_integrator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire doi_pkg::doi_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output doi_pkg::doi_out_t               out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [doi_pkg::QUAD_W-1:0] cfg_wdata_i
);
  import doi_pkg::*;

  doi_cmd_t cmd;

  doi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  doi_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> sv/doi_checker.sv
// port-level checker for the odometry integrator, bound to the top level
// depends on doi_pkg
`default_nettype none

module doi_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire doi_pkg::doi_out_t out_data_o
);
  import doi_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

endmodule

bind differential_odometry_integrator doi_checker u_chk (.*);

`default_nettype wire

>>> dv/differential_odometry_integrator_tb.sv
// testbench for differential_odometry_integrator: directed and random wheel and gyro samples
// checked against an in-bench dead-reckoning predictor, with random idling on both channels
// depends on doi_pkg and the differential_odometry_integrator module

module differential_odometry_integrator_tb;
  import doi_pkg::*;

  localparam int ROT_N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int RND_SH = WORK_FRAC - FRACTION_BITS;
  localparam longint GAIN_K = 163008219;
  localparam longint GYRO_BIAS = 64'sd96636764160;
  localparam logic signed [31:0] ENC_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] ENC_MIN = 32'sh80000000;
  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  doi_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  doi_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [QUAD_W-1:0] cfg_wdata_i = '0;

  differential_odometry_integrator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  doi_in_t sample_q[$];
  doi_out_t pose_expected[$];
  int mismatches = 0;
  int idle_pct = 22;

  logic signed [31:0] prev_right = '0;
  logic signed [31:0] prev_left = '0;
  logic [47:0] track_x = '0;
  logic [47:0] track_y = '0;
  logic [1:0] quad_model = '0;

  logic signed [31:0] gen_r = '0;
  logic signed [31:0] gen_l = '0;
  logic signed [31:0] gen_g = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic doi_out_t odo_predict(doi_in_t smp);
    longint dr, dl, s, x, y, z, xs, ys, gv, q;
    logic [15:0] g_ang, hd, a;
    doi_out_t res;
    dr = longint'(smp.right_position) - longint'(prev_right);
    dl = longint'(smp.left_position) - longint'(prev_left);
    s = dr + dl;
    gv = longint'(smp.gyro_rotation) * 32 + 22 + GYRO_BIAS;
    q = gv / 45;
    g_ang = q[15:0];
    hd = {quad_model, 14'b0} - g_ang;
    a = hd;
    x = s * GAIN_K;
    y = 0;
    // fold the back half-plane onto the front one
    if (a >= 16'd16384 && a < 16'd49152) begin
      x = -x;
      a = a - 16'd32768;
    end
    z = longint'($signed(a)) * 65536;
    for (int i = 0; i < ROT_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN[i];
      end
    end
    x = (x + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    y = (y + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    track_x = track_x + x[47:0];
    track_y = track_y + y[47:0];
    prev_right = smp.right_position;
    prev_left = smp.left_position;
    res.pos_x = track_x;
    res.pos_y = track_y;
    res.heading = hd;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pose_expected.push_back(odo_predict(in_data_i));
        void'(sample_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= sample_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    doi_out_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
      if (out_valid_o && !out_stall_i) begin
        if (pose_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result x=%h y=%h heading=%h",
                     out_data_o.pos_x, out_data_o.pos_y, out_data_o.heading);
        end else begin
          want = pose_expected.pop_front();
          if (out_data_o.pos_x !== want.pos_x || out_data_o.pos_y !== want.pos_y ||
              out_data_o.heading !== want.heading) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp x=%h y=%h heading=%h got x=%h y=%h heading=%h",
                       want.pos_x, want.pos_y, want.heading,
                       out_data_o.pos_x, out_data_o.pos_y, out_data_o.heading);
          end
        end
      end
    end
  end

  task automatic add_sample(input logic signed [31:0] r, input logic signed [31:0] l,
                            input logic signed [31:0] g);
    doi_in_t smp;
    smp.right_position = r;
    smp.left_position = l;
    smp.gyro_rotation = g;
    sample_q.push_back(smp);
  endtask

  function automatic logic signed [31:0] pick_extreme();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = ENC_MAX;
      1: v = ENC_MIN;
      2: v = '0;
      default: v = '1;
    endcase
    return v;
  endfunction

  task automatic add_random_sample();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      // smooth driving
      gen_r = gen_r + ($signed($urandom_range(0, 4000)) - 2000);
      gen_l = gen_l + ($signed($urandom_range(0, 4000)) - 2000);
      gen_g = gen_g + ($signed($urandom_range(0, 20000)) - 10000);
    end else if (mode < 75) begin
      gen_r = $urandom;
      gen_l = $urandom;
      gen_g = $urandom;
    end else if (mode < 85) begin
      gen_r = pick_extreme();
      gen_l = pick_extreme();
      gen_g = pick_extreme();
    end else begin
      // encoder jump
      gen_r = gen_r + $signed($urandom);
      gen_l = gen_l - $signed($urandom_range(0, 32'h3fffffff));
      gen_g = gen_g + $signed($urandom_range(0, 32'h00ffffff));
    end
    add_sample(gen_r, gen_l, gen_g);
  endtask

  task automatic write_quadrant(input logic [1:0] qv);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= qv;
    quad_model = qv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sender holds off until every request has its result
  task automatic wait_drained();
    while (sample_q.size() != 0 || pose_expected.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_quadrant(2'd0);
    add_sample(0, 0, 0);
    add_sample(1000, 1000, 0);
    add_sample(1000, 1000, -23040);
    add_sample(2000, 2000, -23039);
    add_sample(3000, 3000, 46080);
    add_sample(4000, 4000, 23040);
    add_sample(5000, 5000, 23041);
    add_sample(ENC_MAX, ENC_MAX, ENC_MAX);
    add_sample(ENC_MIN, ENC_MIN, ENC_MIN);
    add_sample(ENC_MAX, ENC_MIN, 0);
    add_sample(ENC_MIN, ENC_MAX, -1);
    add_sample(-1, -1, 1);
    add_sample(ENC_MAX, ENC_MAX, 12345);
    add_sample(0, 0, -12345);
    add_sample(5, 4, -23040);
    wait_drained();

    write_quadrant(2'd3);
    add_sample(100, -100, 0);
    add_sample(ENC_MAX, ENC_MAX, 0);
    add_sample(ENC_MIN, ENC_MIN, 23040);
    add_sample(0, 0, -46080);
    add_sample(7, 6, 1);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      write_quadrant((ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3)));
      idle_pct = (ph == 4) ? 0 : 22;
      for (int k = 0; k < 115; k++)
        add_random_sample();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
